>>> src/frame_timing_search_unit_assert.svh
// Assertion macros of the frame timing search RTL.
`ifndef FRAME_TIMING_SEARCH_UNIT_ASSERT_SVH
`define FRAME_TIMING_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define FTS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame timing search check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define FTS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame timing search check failed");

`endif

>>> src/fts_pkg.sv
// Types and constants of the frame timing search unit.
package fts_pkg;

    localparam int MCLK_W     = 27;
    localparam int RATE_W     = 16;
    localparam int LEN_W      = 16;
    localparam int CNT_W      = 16;
    localparam int ERR_W      = 16;
    localparam int CLKDIV_W   = 4;
    localparam int CPF_W      = 32;
    localparam int MIN_W      = 9;
    localparam int DIVIDEND_W = 34;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_CLOCK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BIT_BUS = 1'd1;

    localparam logic [MCLK_W-1:0] MCLK_RESET = 27'd24000000;
    localparam logic [MCLK_W-1:0] CLK_HIGH   = 27'd24000000;
    localparam logic [MCLK_W-1:0] CLK_MID    = 27'd12000000;

    localparam logic [MIN_W-1:0] MIN_LEN_BIN  = 9'd215;
    localparam logic [MIN_W-1:0] MIN_LEN_FULL = 9'd376;
    localparam logic [MIN_W-1:0] MIN_CNT_BIN  = 9'd172;
    localparam logic [MIN_W-1:0] MIN_CNT_QVGA = 9'd260;
    localparam logic [MIN_W-1:0] MIN_CNT_FULL = 9'd344;

    localparam logic [CPF_W-1:0] CPF_MAX = '1;

    localparam logic [CLKDIV_W-1:0] CLKDIV_8 = 4'd8;
    localparam logic [CLKDIV_W-1:0] CLKDIV_4 = 4'd4;
    localparam logic [CLKDIV_W-1:0] CLKDIV_2 = 4'd2;

    localparam logic [1:0] DIV_SEL_CPF = 2'd0;
    localparam logic [1:0] DIV_SEL_TOP = 2'd1;
    localparam logic [1:0] DIV_SEL_LC  = 2'd2;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

    typedef struct packed {
        logic       load;
        logic       cpf_max;
        logic       div_start;
        logic [1:0] div_sel;
        logic       cpf_take;
        logic       top_take;
        logic       eval;
        logic       publish;
    } cmd_t;

    typedef struct packed {
        logic rate_zero;
        logic div_done;
        logic lc_ok;
        logic out_free;
    } stat_t;

endpackage

>>> src/fts_divider.sv
// Restoring divider that retires one quotient bit per cycle.
module fts_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [fts_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [fts_pkg::DIVISOR_W-1:0]   divisor,
    output logic                            done,
    output logic [fts_pkg::DIVIDEND_W-1:0]  quotient,
    output logic [fts_pkg::DIVISOR_W-1:0]   remainder
);
    import fts_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  count_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;

    logic [DIVISOR_W:0]    partial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_next;

    always_comb
    begin
        partial  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = partial - {1'b0, divisor_reg};
        ge       = (partial >= {1'b0, divisor_reg});
        rem_next = ge ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == DIV_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> src/fts_datapath.sv
// Datapath of the frame timing search: settings, search registers and result register.
`include "frame_timing_search_unit_assert.svh"

module fts_datapath #(
    parameter int LINES_PER_FRAME_CAP = 65535
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fts_pkg::MCLK_W-1:0]      cfg_data,
    input  logic [fts_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fts_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  fts_pkg::cmd_t                   cmd,
    output fts_pkg::stat_t                  stat
);
    import fts_pkg::*;

    logic [MCLK_W-1:0]     mclk_reg;
    logic                  four_bit_reg;
    logic                  found_reg;
    logic                  m_valid_reg;

    logic [RATE_W-1:0]     rate_reg;
    logic [MIN_W-1:0]      min_len_reg;
    logic [MIN_W-1:0]      min_cnt_reg;
    logic [CLKDIV_W-1:0]   clkdiv_reg;
    logic [1:0]            shift_reg;
    logic [CPF_W-1:0]      cpf_reg;
    logic                  sat_reg;
    logic [CNT_W-1:0]      lc_reg;
    logic [CPF_W:0]        best_len_reg;
    logic [CNT_W-1:0]      best_cnt_reg;
    logic [ERR_W-1:0]      best_err_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic [CLKDIV_W-1:0]   clkdiv_sel;
    logic [1:0]            shift_sel;
    logic [MCLK_W-1:0]     mclk_shifted;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;
    logic [DIVISOR_W-1:0]  div_rem;
    logic [DIVIDEND_W-1:0] top_sum;

    logic [CPF_W:0]        base0;
    logic [CPF_W:0]        base1;
    logic                  ok0;
    logic                  ok1;
    logic [ERR_W-1:0]      err1;
    logic                  take0;
    logic                  take1;
    logic                  found_mid;
    logic [ERR_W-1:0]      err_mid;
    logic                  len_clip;
    logic [LEN_W-1:0]      len_out;

    always_comb
    begin
        if ((mclk_reg > CLK_HIGH) || !four_bit_reg)
        begin
            clkdiv_sel = CLKDIV_8;
            shift_sel  = 2'd3;
        end
        else if (mclk_reg > CLK_MID)
        begin
            clkdiv_sel = CLKDIV_4;
            shift_sel  = 2'd2;
        end
        else
        begin
            clkdiv_sel = CLKDIV_2;
            shift_sel  = 2'd1;
        end
    end

    assign mclk_shifted = mclk_reg >> shift_reg;

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_SEL_CPF:
            begin
                div_dividend = {mclk_shifted[MCLK_W-2:0], 8'd0};
                div_divisor  = rate_reg;
            end
            DIV_SEL_TOP:
            begin
                div_dividend = {2'b00, cpf_reg};
                div_divisor  = {{(DIVISOR_W-MIN_W){1'b0}}, min_len_reg};
            end
            DIV_SEL_LC:
            begin
                div_dividend = {2'b00, cpf_reg};
                div_divisor  = lc_reg;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    fts_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign top_sum = div_quo + {{(DIVIDEND_W-1){1'b0}}, (div_rem != '0)};

    // The two lengths around cpf / count: the lower leaves the remainder, the upper
    // overshoots by count minus the remainder.
    always_comb
    begin
        base0     = {1'b0, div_quo[CPF_W-1:0]};
        base1     = base0 + 1'b1;
        ok0       = (base0 >= {{(CPF_W+1-MIN_W){1'b0}}, min_len_reg});
        ok1       = (base1 >= {{(CPF_W+1-MIN_W){1'b0}}, min_len_reg});
        err1      = lc_reg - div_rem;
        take0     = ok0 && (!found_reg || (div_rem < best_err_reg));
        found_mid = found_reg || take0;
        err_mid   = take0 ? div_rem : best_err_reg;
        take1     = ok1 && (!found_mid || (err1 < err_mid));
    end

    always_comb
    begin
        len_clip = (best_len_reg > {{(CPF_W+1-LEN_W){1'b0}}, {LEN_W{1'b1}}});
        len_out  = len_clip ? {LEN_W{1'b1}} : best_len_reg[LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mclk_reg     <= MCLK_RESET;
            four_bit_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MASTER_CLOCK: mclk_reg     <= cfg_data;
                    CFG_FOUR_BIT_BUS: four_bit_reg <= cfg_data[0];
                    default:          mclk_reg     <= mclk_reg;
                endcase
            end
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.eval)
            begin
                found_reg <= found_mid || take1;
            end
            if (cmd.publish)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rate_reg     <= s_tdata[RATE_W-1:0];
            clkdiv_reg   <= clkdiv_sel;
            shift_reg    <= shift_sel;
            sat_reg      <= 1'b0;
            best_err_reg <= '0;
            if (s_tdata[RATE_W])
            begin
                min_len_reg  <= MIN_LEN_BIN;
                min_cnt_reg  <= MIN_CNT_BIN;
                best_len_reg <= {{(CPF_W+1-MIN_W){1'b0}}, MIN_LEN_BIN};
                best_cnt_reg <= {{(CNT_W-MIN_W){1'b0}}, MIN_CNT_BIN};
            end
            else
            begin
                min_len_reg  <= MIN_LEN_FULL;
                min_cnt_reg  <= s_tdata[RATE_W+1] ? MIN_CNT_QVGA : MIN_CNT_FULL;
                best_len_reg <= {{(CPF_W+1-MIN_W){1'b0}}, MIN_LEN_FULL};
                best_cnt_reg <= {{(CNT_W-MIN_W){1'b0}},
                                 s_tdata[RATE_W+1] ? MIN_CNT_QVGA : MIN_CNT_FULL};
            end
        end
        if (cmd.cpf_max)
        begin
            cpf_reg <= CPF_MAX;
            sat_reg <= 1'b1;
        end
        if (cmd.cpf_take)
        begin
            if (div_quo[DIVIDEND_W-1:CPF_W] != '0)
            begin
                cpf_reg <= CPF_MAX;
                sat_reg <= 1'b1;
            end
            else
            begin
                cpf_reg <= div_quo[CPF_W-1:0];
            end
        end
        if (cmd.top_take)
        begin
            if (top_sum > DIVIDEND_W'(LINES_PER_FRAME_CAP))
            begin
                lc_reg  <= CNT_W'(LINES_PER_FRAME_CAP);
                sat_reg <= 1'b1;
            end
            else
            begin
                lc_reg <= top_sum[CNT_W-1:0];
            end
        end
        if (cmd.eval)
        begin
            lc_reg <= lc_reg - 1'b1;
            if (take1)
            begin
                best_len_reg <= base1;
                best_cnt_reg <= lc_reg;
                best_err_reg <= err1;
            end
            else if (take0)
            begin
                best_len_reg <= base0;
                best_cnt_reg <= lc_reg;
                best_err_reg <= div_rem;
            end
        end
        if (cmd.publish)
        begin
            m_data_reg <= {2'b00, sat_reg | len_clip, found_reg, clkdiv_reg,
                           best_err_reg, best_cnt_reg, len_out};
        end
    end

    assign stat.rate_zero = (rate_reg == '0);
    assign stat.div_done  = div_done;
    assign stat.lc_ok     = (lc_reg >= {{(CNT_W-MIN_W){1'b0}}, min_cnt_reg});
    assign stat.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `FTS_ASSERT_IMP(a_eval_in_range, cmd.eval,
        (lc_reg >= {{(CNT_W-MIN_W){1'b0}}, min_cnt_reg}))
    `FTS_ASSERT_IMP(a_publish_free, cmd.publish, (!m_valid_reg || m_tready))
    `FTS_ASSERT_IMP(a_found_len_min, found_reg,
        (best_len_reg >= {{(CPF_W+1-MIN_W){1'b0}}, min_len_reg}))
    `FTS_ASSERT_NXT(a_load_clears_found, cmd.load, !found_reg)

endmodule

>>> src/fts_ctrl.sv
// Controller of the frame timing search: sequences the divisions and the line count sweep.
module fts_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  fts_pkg::stat_t  stat,
    output fts_pkg::cmd_t   cmd
);
    import fts_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CPF      = 3'd1;
    localparam logic [2:0] ST_CPF_WAIT = 3'd2;
    localparam logic [2:0] ST_TOP      = 3'd3;
    localparam logic [2:0] ST_TOP_WAIT = 3'd4;
    localparam logic [2:0] ST_CHECK    = 3'd5;
    localparam logic [2:0] ST_LC_WAIT  = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CPF;
                end
            end
            ST_CPF:
            begin
                if (stat.rate_zero)
                begin
                    cmd.cpf_max = 1'b1;
                    state_next  = ST_TOP;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_CPF;
                    state_next    = ST_CPF_WAIT;
                end
            end
            ST_CPF_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.cpf_take = 1'b1;
                    state_next   = ST_TOP;
                end
            end
            ST_TOP:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_TOP;
                state_next    = ST_TOP_WAIT;
            end
            ST_TOP_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.top_take = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.lc_ok)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_LC;
                    state_next    = ST_LC_WAIT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LC_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.eval   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

>>> src/frame_timing_search_unit.sv
// Top level of the frame timing search unit.
// Each request on the slave stream carries a target frame rate and the sensor mode; the
// block answers with one result on the master stream holding the line length, line
// count, error, clock divider and the found and saturated flags.
// Settings are written through cfg_we, cfg_index and cfg_data while no request is open:
// index 0 is the master clock in hertz, index 1 selects the four bit pixel bus.
// One request is worked on at a time. A shared divider that retires one quotient bit per
// cycle sets the time: it runs one division for the clocks per frame, one for the
// starting line count and one for each line count from the start down to the mode
// minimum; a zero rate skips the clocks per frame division. The block is ready for the
// next request once the result is loaded.
// The result sits in an output register; a new request is taken while it waits, and a
// finished search holds until that register is free, so a stalled receiver stalls
// the block only after the next search is done.
// Reset returns the settings to a 24 MHz master clock with the four bit bus deselected and empties
// the output register; no memory needs clearing.
// s_tdata: frame_rate_q8[15:0], binning[16], quarter_vga[17], zero padding.
// m_tdata: line_clocks[15:0], frame_lines[31:16], frame_error[47:32],
//          clock_divider[51:48], found[52], saturated[53], zero padding.
module frame_timing_search_unit #(
    parameter int LINES_PER_FRAME_CAP = 65535
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fts_pkg::MCLK_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // frame_rate_q8, binning, quarter_vga from the lowest bit up
    input  logic [fts_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // line_clocks, frame_lines, frame_error, clock_divider, found, saturated
    output logic [fts_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import fts_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fts_datapath #(
        .LINES_PER_FRAME_CAP (LINES_PER_FRAME_CAP)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
